FILE: rtl/owb_pkg.sv
// Shared types and constants for the one-wire byte master.
package owb_pkg;

    localparam int CFG_ADDR_BITS = 5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_IDLE_HIGH     = 3'd0,
        REG_RESET_LOW     = 3'd1,
        REG_PRESENCE_WAIT = 3'd2,
        REG_PULSE_LOW     = 3'd3,
        REG_SLOT          = 3'd4,
        REG_BYTE_GAP      = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_HIGH = 4'd1,
        PH_RST_LOW  = 4'd2,
        PH_RST_WAIT = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_HIGH   = 4'd5,
        PH_W_GAP    = 4'd6,
        PH_R_LOW    = 4'd7,
        PH_R_SAMPLE = 4'd8,
        PH_R_WAIT   = 4'd9
    } phase_t;

    localparam logic [15:0] RST_IDLE_HIGH     = 16'd100;
    localparam logic [15:0] RST_RESET_LOW     = 16'd600;
    localparam logic [15:0] RST_PRESENCE_WAIT = 16'd240;
    localparam logic [7:0]  RST_PULSE_LOW     = 8'd2;
    localparam logic [15:0] RST_SLOT          = 16'd60;
    localparam logic [15:0] RST_BYTE_GAP      = 16'd30;

    typedef struct packed {
        logic [15:0] idle_high;
        logic [15:0] reset_low;
        logic [15:0] presence_wait;
        logic [7:0]  pulse_low;
        logic [15:0] slot;
        logic [15:0] byte_gap;
    } cfg_t;

    typedef struct packed {
        logic       rejected;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

endpackage

FILE: rtl/owb_cfg.sv
// APB register file holding the bus timing counts.
module owb_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [owb_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output owb_pkg::cfg_t                      cfg
);
    import owb_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_IDLE_HIGH:     cfg_next.idle_high     = pwdata[15:0];
                REG_RESET_LOW:     cfg_next.reset_low     = pwdata[15:0];
                REG_PRESENCE_WAIT: cfg_next.presence_wait = pwdata[15:0];
                REG_PULSE_LOW:     cfg_next.pulse_low     = pwdata[7:0];
                REG_SLOT:          cfg_next.slot          = pwdata[15:0];
                REG_BYTE_GAP:      cfg_next.byte_gap      = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_IDLE_HIGH:     prdata = {16'd0, cfg_reg.idle_high};
            REG_RESET_LOW:     prdata = {16'd0, cfg_reg.reset_low};
            REG_PRESENCE_WAIT: prdata = {16'd0, cfg_reg.presence_wait};
            REG_PULSE_LOW:     prdata = {24'd0, cfg_reg.pulse_low};
            REG_SLOT:          prdata = {16'd0, cfg_reg.slot};
            REG_BYTE_GAP:      prdata = {16'd0, cfg_reg.byte_gap};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_high     <= RST_IDLE_HIGH;
            cfg_reg.reset_low     <= RST_RESET_LOW;
            cfg_reg.presence_wait <= RST_PRESENCE_WAIT;
            cfg_reg.pulse_low     <= RST_PULSE_LOW;
            cfg_reg.slot          <= RST_SLOT;
            cfg_reg.byte_gap      <= RST_BYTE_GAP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/owb_fsm.sv
// Bus sequencer: phase, tick timer, bit counter and shift register.
module owb_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  owb_pkg::cmd_t       cmd,
    input  logic [7:0]          data_byte,
    input  logic                line_level,
    input  owb_pkg::cfg_t       cfg,
    output owb_pkg::res_t       res
);
    import owb_pkg::*;

    localparam logic [15:0] LOAD_MAX =
        (TIMER_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << TIMER_BITS) - 64'd1);

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [3:0]            bit_reg, bit_next, bit_inc;
    logic [7:0]            shift_reg, shift_next, shift_dn;
    logic                  pull_reg, pull_next;
    cmd_t                  op_reg, op_next;
    logic [7:0]            last_reg, last_next;
    logic                  ends;
    logic                  done;
    logic                  rejected;

    function automatic logic [TIMER_BITS-1:0] sat(input logic [15:0] v);
        logic [15:0] c;
        c = (v > LOAD_MAX) ? LOAD_MAX : v;
        return TIMER_BITS'(c);
    endfunction

    assign ends     = (timer_reg <= TIMER_BITS'(1));
    assign bit_inc  = bit_reg + 4'd1;
    assign shift_dn = {1'b0, shift_reg[7:1]};

    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pull_next  = pull_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        done       = 1'b0;
        rejected   = 1'b0;
        if (in_fire) begin
            if (cmd != CMD_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    op_next  = cmd;
                    bit_next = 4'd0;
                    case (cmd)
                        CMD_RESET: begin
                            phase_next = PH_RST_HIGH;
                            timer_next = sat(cfg.idle_high);
                            pull_next  = 1'b0;
                        end
                        CMD_WRITE: begin
                            shift_next = data_byte;
                            phase_next = PH_W_LOW;
                            timer_next = data_byte[0] ? sat({8'd0, cfg.pulse_low})
                                                      : sat(cfg.slot);
                            pull_next  = 1'b1;
                        end
                        default: begin
                            shift_next = 8'd0;
                            phase_next = PH_R_LOW;
                            timer_next = sat({8'd0, cfg.pulse_low});
                            pull_next  = 1'b1;
                        end
                    endcase
                end
            end else begin
                if (phase_reg != PH_IDLE && phase_reg != PH_R_SAMPLE) begin
                    timer_next = ends ? '0 : timer_reg - TIMER_BITS'(1);
                end
                case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_RST_HIGH: begin
                        if (ends) begin
                            phase_next = PH_RST_LOW;
                            timer_next = sat(cfg.reset_low);
                            pull_next  = 1'b1;
                        end
                    end
                    PH_RST_LOW: begin
                        if (ends) begin
                            phase_next = PH_RST_WAIT;
                            timer_next = sat(cfg.presence_wait);
                            pull_next  = 1'b0;
                        end
                    end
                    PH_RST_WAIT, PH_W_GAP: begin
                        if (ends) begin
                            phase_next = PH_IDLE;
                            pull_next  = 1'b0;
                            op_next    = CMD_TICK;
                            done       = 1'b1;
                        end
                    end
                    PH_W_LOW: begin
                        if (ends) begin
                            phase_next = PH_W_HIGH;
                            timer_next = shift_reg[0] ? sat(cfg.slot)
                                                      : sat({8'd0, cfg.pulse_low});
                            pull_next  = 1'b0;
                        end
                    end
                    PH_W_HIGH: begin
                        if (ends) begin
                            shift_next = shift_dn;
                            bit_next   = bit_inc;
                            if (bit_inc[3]) begin
                                if (cfg.byte_gap == 16'd0) begin
                                    phase_next = PH_IDLE;
                                    pull_next  = 1'b0;
                                    op_next    = CMD_TICK;
                                    done       = 1'b1;
                                end else begin
                                    phase_next = PH_W_GAP;
                                    timer_next = sat(cfg.byte_gap);
                                    pull_next  = 1'b0;
                                end
                            end else begin
                                phase_next = PH_W_LOW;
                                timer_next = shift_dn[0] ? sat({8'd0, cfg.pulse_low})
                                                         : sat(cfg.slot);
                                pull_next  = 1'b1;
                            end
                        end
                    end
                    PH_R_LOW: begin
                        if (ends) begin
                            phase_next = PH_R_SAMPLE;
                            timer_next = '0;
                            pull_next  = 1'b0;
                        end
                    end
                    PH_R_SAMPLE: begin
                        shift_next = {line_level, shift_reg[7:1]};
                        phase_next = PH_R_WAIT;
                        timer_next = sat(cfg.slot);
                        pull_next  = 1'b0;
                    end
                    PH_R_WAIT: begin
                        if (ends) begin
                            bit_next = bit_inc;
                            if (bit_inc[3]) begin
                                last_next  = shift_reg;
                                phase_next = PH_IDLE;
                                pull_next  = 1'b0;
                                op_next    = CMD_TICK;
                                done       = 1'b1;
                            end else begin
                                phase_next = PH_R_LOW;
                                timer_next = sat({8'd0, cfg.pulse_low});
                                pull_next  = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        pull_next  = 1'b0;
                        op_next    = CMD_TICK;
                    end
                endcase
                if (phase_next == PH_IDLE) begin
                    timer_next = '0;
                end
            end
        end
    end

    always_comb begin
        res.drive_low = pull_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.read_data = last_next;
        res.rejected  = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            pull_reg  <= 1'b0;
            op_reg    <= CMD_TICK;
            last_reg  <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pull_reg  <= pull_next;
            op_reg    <= op_next;
            last_reg  <= last_next;
        end
    end

endmodule

FILE: rtl/one_wire_byte_master_top.sv
// Result: each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the output register frees as it is read,
// so input is taken whenever the result slot is empty or being drained.
// Reset (aresetn low, synchronous): sequencer idle, line released, last read
// byte 0, output empty, timing registers back to their default counts.
module one_wire_byte_master_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // data_byte, line_level, pad
    input  logic [1:0]                         s_tuser,  // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_low, busy_res, done_res, read_data[7:0], rejected, pad
    output logic [15:0]                        m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [owb_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import owb_pkg::*;

    cfg_t        cfg;
    res_t        res;
    logic        in_fire;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    owb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owb_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .cmd        (cmd_t'(s_tuser)),
        .data_byte  (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= {4'd0, res};
        end
    end

endmodule

FILE: rtl/owb_checker.sv
// Port-level checker for the one-wire byte master, bound to the top level.
module owb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0] && !m_tdata[11])
        else $error("done beat shows busy, pull or reject");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[1])
        else $error("reject while idle");

    a_pull_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("line pulled while idle");

endmodule

bind one_wire_byte_master_top owb_checker u_owb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_one_wire_byte_master_top.sv
// Self-checking bench for the one-wire byte master: random and directed bus operations.
`timescale 1ns / 100ps

module tb_one_wire_byte_master_top;
    import owb_pkg::*;

    localparam int NUM_REGS       = 6;
    localparam int FIRST_UNMAPPED = 6;
    localparam int RANDOM_BEATS   = 450;
    localparam int SETUP_BEATS    = 150;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LEVEL_LOW      = 0;
    localparam int LEVEL_HIGH     = 1;
    localparam int LEVEL_RANDOM   = 2;

    // Expected-result tracker: mirrors the bus sequencer and queues one result per beat.
    class bus_scoreboard;
        cfg_t        cfg;
        phase_t      seq_phase;
        logic [15:0] tick_left;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift_byte;
        logic        line_low;
        cmd_t        op_kind;
        logic [7:0]  last_byte;
        res_t        pending_res[$];
        int          ops_done[4];
        int          refused;

        function new();
            cfg.idle_high     = RST_IDLE_HIGH;
            cfg.reset_low     = RST_RESET_LOW;
            cfg.presence_wait = RST_PRESENCE_WAIT;
            cfg.pulse_low     = RST_PULSE_LOW;
            cfg.slot          = RST_SLOT;
            cfg.byte_gap      = RST_BYTE_GAP;
            seq_phase  = PH_IDLE;
            tick_left  = '0;
            bit_cnt    = '0;
            shift_byte = '0;
            line_low   = 1'b0;
            op_kind    = CMD_TICK;
            last_byte  = '0;
            refused    = 0;
            foreach (ops_done[i]) ops_done[i] = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] val);
            case (idx)
                REG_IDLE_HIGH:     cfg.idle_high     = val[15:0];
                REG_RESET_LOW:     cfg.reset_low     = val[15:0];
                REG_PRESENCE_WAIT: cfg.presence_wait = val[15:0];
                REG_PULSE_LOW:     cfg.pulse_low     = val[7:0];
                REG_SLOT:          cfg.slot          = val[15:0];
                REG_BYTE_GAP:      cfg.byte_gap      = val[15:0];
                default: ;
            endcase
        endfunction

        function void load(phase_t ph, logic [15:0] ticks, logic drv);
            seq_phase = ph;
            tick_left = ticks;
            line_low  = drv;
        endfunction

        function bit expired();
            if (tick_left <= 16'd1) begin
                tick_left = '0;
                return 1'b1;
            end
            tick_left = tick_left - 16'd1;
            return 1'b0;
        endfunction

        function void start_write_bit();
            load(PH_W_LOW, shift_byte[0] ? 16'(cfg.pulse_low) : cfg.slot, 1'b1);
        endfunction

        function void end_op();
            ops_done[op_kind]++;
            seq_phase = PH_IDLE;
            tick_left = '0;
            line_low  = 1'b0;
            op_kind   = CMD_TICK;
        endfunction

        function void take_command(cmd_t c, logic [7:0] d, logic lv);
            res_t r;
            logic done;
            logic rej;
            done = 1'b0;
            rej  = 1'b0;
            if (c != CMD_TICK) begin
                if (seq_phase != PH_IDLE) begin
                    rej = 1'b1;
                    refused++;
                end else begin
                    op_kind = c;
                    bit_cnt = '0;
                    case (c)
                        CMD_RESET: load(PH_RST_HIGH, cfg.idle_high, 1'b0);
                        CMD_WRITE: begin
                            shift_byte = d;
                            start_write_bit();
                        end
                        default: begin
                            shift_byte = '0;
                            load(PH_R_LOW, 16'(cfg.pulse_low), 1'b1);
                        end
                    endcase
                end
            end else begin
                case (seq_phase)
                    PH_RST_HIGH: if (expired()) load(PH_RST_LOW, cfg.reset_low, 1'b1);
                    PH_RST_LOW:  if (expired()) load(PH_RST_WAIT, cfg.presence_wait, 1'b0);
                    PH_RST_WAIT: if (expired()) begin
                        end_op();
                        done = 1'b1;
                    end
                    PH_W_LOW: if (expired())
                        load(PH_W_HIGH, shift_byte[0] ? cfg.slot : 16'(cfg.pulse_low), 1'b0);
                    PH_W_HIGH: if (expired()) begin
                        shift_byte = shift_byte >> 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8) begin
                            if (cfg.byte_gap == 16'd0) begin
                                end_op();
                                done = 1'b1;
                            end else begin
                                load(PH_W_GAP, cfg.byte_gap, 1'b0);
                            end
                        end else begin
                            start_write_bit();
                        end
                    end
                    PH_W_GAP: if (expired()) begin
                        end_op();
                        done = 1'b1;
                    end
                    PH_R_LOW: if (expired()) load(PH_R_SAMPLE, 16'd0, 1'b0);
                    PH_R_SAMPLE: begin
                        shift_byte = {lv, shift_byte[7:1]};
                        load(PH_R_WAIT, cfg.slot, 1'b0);
                    end
                    PH_R_WAIT: if (expired()) begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8) begin
                            last_byte = shift_byte;
                            end_op();
                            done = 1'b1;
                        end else begin
                            load(PH_R_LOW, 16'(cfg.pulse_low), 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
            r.drive_low = line_low;
            r.busy_res  = (seq_phase != PH_IDLE);
            r.done_res  = done;
            r.read_data = last_byte;
            r.rejected  = rej;
            pending_res.push_back(r);
        endfunction

        function string match_result(res_t got);
            res_t  want;
            string msg;
            if (pending_res.size() == 0)
                return $sformatf("result beat %h with nothing expected", got);
            want = pending_res.pop_front();
            msg = "";
            if (got.drive_low !== want.drive_low)
                msg = {msg, $sformatf(" drive_low %b exp %b", got.drive_low, want.drive_low)};
            if (got.busy_res !== want.busy_res)
                msg = {msg, $sformatf(" busy %b exp %b", got.busy_res, want.busy_res)};
            if (got.done_res !== want.done_res)
                msg = {msg, $sformatf(" done %b exp %b", got.done_res, want.done_res)};
            if (got.read_data !== want.read_data)
                msg = {msg, $sformatf(" read_data %h exp %h", got.read_data, want.read_data)};
            if (got.rejected !== want.rejected)
                msg = {msg, $sformatf(" rejected %b exp %b", got.rejected, want.rejected)};
            return msg;
        endfunction
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata  = '0;
    logic [1:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [15:0]              m_tdata;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [31:0]              pwdata   = '0;
    logic [31:0]              prdata;
    logic                     pready;

    bus_scoreboard sb;
    int mismatches = 0;
    int cycles     = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int setups     = 0;
    int rdy_left   = 0;
    bit rdy_on     = 1'b0;

    one_wire_byte_master_top #(.TIMER_BITS(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_one_wire_byte_master_top failed");
            $finish;
        end
    end

    // receiver: ready runs of random length, short stalls, now and then a long clean run
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_on = !rdy_on;
            if (rdy_on)
                rdy_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
            else
                rdy_left = $urandom_range(1, 5);
        end else begin
            rdy_left--;
        end
        m_tready <= rdy_on;
    end

    always @(posedge aclk) begin : result_mon
        string msg;
        if (aresetn && m_tvalid && m_tready) begin
            msg = sb.match_result(res_t'(m_tdata[11:0]));
            if (msg != "") report_mismatch(msg);
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20) $display("MISMATCH at %0t:%s", $time, what);
    endtask

    task automatic send_beat(input cmd_t c, input logic [7:0] d, input logic lv);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {7'b0, lv, d};
        do @(posedge aclk); while (!s_tready);
        sb.take_command(c, d, lv);
        beats_sent++;
        burst_left--;
    endtask

    function automatic logic pick_level(int mode);
        if (mode == LEVEL_LOW) return 1'b0;
        if (mode == LEVEL_HIGH) return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // tick the bus until the running operation ends; sometimes a start slips in and is refused
    task automatic tick_until_idle(input int mode);
        while (sb.seq_phase != PH_IDLE) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(cmd_t'($urandom_range(1, 3)), 8'($urandom), pick_level(mode));
            else
                send_beat(CMD_TICK, 8'($urandom), pick_level(mode));
        end
    endtask

    task automatic run_op(input cmd_t c, input logic [7:0] d, input int mode);
        send_beat(c, d, pick_level(mode));
        tick_until_idle(mode);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_res.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_timing(input int ih, input int rl, input int pw,
                              input int pl, input int sl, input int bg);
        int          vals[NUM_REGS];
        logic [31:0] hi;
        vals[REG_IDLE_HIGH]     = ih;
        vals[REG_RESET_LOW]     = rl;
        vals[REG_PRESENCE_WAIT] = pw;
        vals[REG_PULSE_LOW]     = pl;
        vals[REG_SLOT]          = sl;
        vals[REG_BYTE_GAP]      = bg;
        wait_drained();
        for (int i = 0; i < NUM_REGS; i++) begin
            hi = (i == REG_PULSE_LOW) ? 32'hFFFF_FF00 : 32'hFFFF_0000;
            apb_write(i, 32'(vals[i]) | (($urandom_range(0, 3) == 0) ? ($urandom & hi) : 32'h0));
        end
        if ($urandom_range(0, 2) == 0)
            apb_write(FIRST_UNMAPPED + $urandom_range(0, 1), $urandom);
        setups++;
    endtask

    function automatic int short_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(5, 12);
        return $urandom_range(1, 4);
    endfunction

    initial begin : stimulus
        int   rand_start;
        int   setup_start;
        int   r;
        cmd_t c;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default timing: idle ticks, a write, starts refused while busy
        send_beat(CMD_TICK, 8'h00, 1'b0);
        send_beat(CMD_TICK, 8'hFF, 1'b1);
        send_beat(CMD_WRITE, 8'h5A, 1'b0);
        send_beat(CMD_RESET, 8'hFF, 1'b1);
        send_beat(CMD_READ, 8'h00, 1'b0);
        send_beat(CMD_WRITE, 8'hC3, 1'b1);
        tick_until_idle(LEVEL_RANDOM);

        // shortest counts with no byte gap
        set_timing(1, 1, 1, 1, 1, 0);
        apb_write(FIRST_UNMAPPED, 32'hFFFF_FFFF);
        apb_write(FIRST_UNMAPPED + 1, 32'h0000_0000);
        run_op(CMD_RESET, 8'h00, LEVEL_RANDOM);
        run_op(CMD_WRITE, 8'h00, LEVEL_RANDOM);
        run_op(CMD_WRITE, 8'hFF, LEVEL_RANDOM);
        run_op(CMD_READ, 8'h00, LEVEL_HIGH);
        run_op(CMD_READ, 8'hFF, LEVEL_LOW);

        // zero counts behave as one, but a zero byte gap skips the gap phase
        set_timing(0, 0, 0, 0, 0, 0);
        run_op(CMD_RESET, 8'h00, LEVEL_RANDOM);
        run_op(CMD_WRITE, 8'hA5, LEVEL_RANDOM);
        run_op(CMD_READ, 8'h00, LEVEL_RANDOM);

        // longest short pulse
        set_timing(3, 2, 3, 255, 1, 2);
        run_op(CMD_WRITE, 8'h96, LEVEL_RANDOM);

        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS) begin
            set_timing(short_count(), short_count(), short_count(),
                       short_count(), short_count(), $urandom_range(0, 6));
            setup_start = beats_sent;
            while (beats_sent - setup_start < SETUP_BEATS) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
                c = cmd_t'($urandom_range(1, 3));
                run_op(c, 8'($urandom), (r < 3) ? $urandom_range(0, 1) : LEVEL_RANDOM);
            end
        end

        // largest counts: start a read and let it run a while
        set_timing(65535, 65535, 65535, 255, 65535, 65535);
        send_beat(CMD_READ, 8'($urandom), 1'b1);
        repeat (300) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
            else
                send_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("run: %0d beats, %0d timing setups including all-zero, minimum and maximum",
                 beats_sent, setups);
        $display("completed %0d resets, %0d writes, %0d reads; %0d starts refused while busy",
                 sb.ops_done[CMD_RESET], sb.ops_done[CMD_WRITE], sb.ops_done[CMD_READ],
                 sb.refused);
        if (mismatches == 0)
            $display("tb_one_wire_byte_master_top passed");
        else
            $display("tb_one_wire_byte_master_top failed");
        $finish;
    end

endmodule
